// ----- hw/rtl/fbfla_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbfla_pkg
// shared types and constants of the fixed block free list allocator
// ----------------------------------------------------------------------------
package fbfla_pkg;

    localparam int POOL_BLOCKS_DEF = 8;

    localparam int LINK_W = 9;
    localparam logic [LINK_W-1:0] EMPTY_MARK = 9'h100;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK              = 3'd0;
    localparam logic [2:0] ST_EXHAUSTED       = 3'd1;
    localparam logic [2:0] ST_BAD_ALLOC_COUNT = 3'd2;
    localparam logic [2:0] ST_OUT_OF_POOL     = 3'd3;
    localparam logic [2:0] ST_FREE_IGNORED    = 3'd4;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ----- hw/rtl/fbfla_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbfla_ctrl
// request sequencer: takes a transaction, then runs its execute cycle
// ----------------------------------------------------------------------------
module fbfla_ctrl
    import fbfla_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    output t_dp_cmd      o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_comb begin
        o_cmd.load = start && !r_busy;
        o_cmd.exec = (r_state == S_EXEC);
    end

    assign busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/fbfla_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbfla_dp
// datapath: link memory, head pointer, allocated count and result register
// ----------------------------------------------------------------------------
module fbfla_dp
    import fbfla_pkg::*;
#(
    parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
)(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    input  wire logic       i_op,
    input  wire logic [7:0] i_block_index,
    input  wire logic [7:0] i_req_count,
    output logic            o_valid,
    output logic [7:0]      o_granted_index,
    output logic [2:0]      o_status,
    output logic [7:0]      o_used_blocks,
    output logic [7:0]      o_free_blocks
);

    localparam int AW = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam logic [LINK_W-1:0] POOL_L = LINK_W'(POOL_BLOCKS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_BLOCKS - 1);

    logic [LINK_W-1:0] mem [POOL_BLOCKS];
    logic [POOL_BLOCKS-1:0] r_link_valid;

    logic [LINK_W-1:0] r_head;
    logic [7:0]        r_used;

    logic              r_op;
    logic [7:0]        r_idx;
    logic [7:0]        r_cnt;
    logic [AW-1:0]     r_rd_addr;
    logic [LINK_W-1:0] r_rd_data;
    logic              r_rd_valid;

    logic [LINK_W-1:0] n_head;
    logic [7:0]        n_used;
    logic [7:0]        n_granted;
    logic [2:0]        n_status;
    logic              n_wr;
    logic [LINK_W-1:0] link_val;
    logic [AW-1:0]     rd_addr;
    logic              head_ok;
    logic              idx_ok;

    assign head_ok = (r_head < POOL_L);
    assign idx_ok  = ({1'b0, r_idx} < POOL_L);
    assign rd_addr = head_ok ? r_head[AW-1:0] : '0;

    // unwritten entries read as their reset link
    always_comb begin
        if (r_rd_valid) begin
            link_val = r_rd_data;
        end else if (r_rd_addr == LAST_ADDR) begin
            link_val = EMPTY_MARK;
        end else begin
            link_val = LINK_W'(r_rd_addr) + LINK_W'(1);
        end
    end

    always_comb begin
        n_head    = r_head;
        n_used    = r_used;
        n_granted = 8'd0;
        n_status  = ST_OK;
        n_wr      = 1'b0;
        if (r_op == OP_ALLOC) begin
            if (r_cnt != 8'd1) begin
                n_status = ST_BAD_ALLOC_COUNT;
            end else if (!head_ok) begin
                n_status = ST_EXHAUSTED;
            end else begin
                n_granted = r_head[7:0];
                n_head    = link_val;
                if (r_used != 8'hff) begin
                    n_used = r_used + 8'd1;
                end
            end
        end else begin
            if (r_cnt != 8'd1) begin
                n_status = ST_FREE_IGNORED;
            end else if (!idx_ok) begin
                n_status = ST_OUT_OF_POOL;
            end else begin
                n_wr   = 1'b1;
                n_head = {1'b0, r_idx};
                if (r_used != 8'd0) begin
                    n_used = r_used - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_data <= mem[rd_addr];
        end
        if (i_cmd.exec && n_wr) begin
            mem[r_idx[AW-1:0]] <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_op;
            r_idx      <= i_block_index;
            r_cnt      <= i_req_count;
            r_rd_addr  <= rd_addr;
            r_rd_valid <= r_link_valid[rd_addr];
        end
        if (i_cmd.exec) begin
            o_granted_index <= n_granted;
            o_status        <= n_status;
            o_used_blocks   <= n_used;
            if ({1'b0, n_used} >= POOL_L) begin
                o_free_blocks <= 8'd0;
            end else begin
                o_free_blocks <= 8'(POOL_L - {1'b0, n_used});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_used       <= '0;
            r_link_valid <= '0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_head <= n_head;
                r_used <= n_used;
                if (n_wr) begin
                    r_link_valid[r_idx[AW-1:0]] <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/fixed_block_free_list_allocator_unit.sv -----
`default_nettype none
// sequence: an accepted start loads the request and reads the link memory,
//   then the execute state updates the head and registers the o_valid strobe;
//   busy holds off a new transaction until the execute state is done
// reset: synchronous active low; head at block 0, no blocks allocated,
//   link memory reads as its initial chain at once
// results cannot be stalled: o_valid is high for exactly one cycle
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_unit
// fixed size block pool with a lifo free list of block indices
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_unit
    import fbfla_pkg::*;
#(
    parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
)(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       i_op,
    input  wire logic [7:0] i_block_index,
    input  wire logic [7:0] i_req_count,
    output logic            o_valid,
    output logic [7:0]      o_granted_index,
    output logic [2:0]      o_status,
    output logic [7:0]      o_used_blocks,
    output logic [7:0]      o_free_blocks
);

    t_dp_cmd cmd;

    fbfla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    fbfla_dp #(
        .POOL_BLOCKS (POOL_BLOCKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (i_op),
        .i_block_index   (i_block_index),
        .i_req_count     (i_req_count),
        .o_valid         (o_valid),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .o_used_blocks   (o_used_blocks),
        .o_free_blocks   (o_free_blocks)
    );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the fixed block free list allocator unit: a short
// table of allocate and free requests, then phased random traffic with a
// saturating allocate burst, checked against table results or a lifo predictor
// ----------------------------------------------------------------------------
module tb;
    import fbfla_pkg::*;

    localparam int POOL_BLOCKS = POOL_BLOCKS_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int BURST_ALLOCS = 280;

    typedef struct packed {
        logic [7:0] granted;
        logic [2:0] status;
        logic [7:0] used;
        logic [7:0] freeb;
    } t_alloc_result;

    typedef struct {
        logic          op;
        logic [7:0]    idx;
        logic [7:0]    cnt;
        bit            typed;
        t_alloc_result res;
    } t_req_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic       i_op;
    logic [7:0] i_block_index;
    logic [7:0] i_req_count;
    logic       o_valid;
    logic [7:0] o_granted_index;
    logic [2:0] o_status;
    logic [7:0] o_used_blocks;
    logic [7:0] o_free_blocks;

    logic [LINK_W-1:0] link_mem [0:POOL_BLOCKS-1];
    logic [LINK_W-1:0] head_ptr;
    logic [7:0]        used_cnt;

    t_alloc_result pending_results[$];
    t_req_row      req_table[$];
    int            mismatch_cnt;
    int            idle_cycles;
    bit            idle_en;

    fixed_block_free_list_allocator_unit #(
        .POOL_BLOCKS (POOL_BLOCKS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_block_index   (i_block_index),
        .i_req_count     (i_req_count),
        .o_valid         (o_valid),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .o_used_blocks   (o_used_blocks),
        .o_free_blocks   (o_free_blocks)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic pool_reset();
        for (int i = 0; i < POOL_BLOCKS; i++) begin
            link_mem[i] = (i == POOL_BLOCKS - 1) ? EMPTY_MARK : LINK_W'(i + 1);
        end
        head_ptr = '0;
        used_cnt = '0;
    endtask

    task automatic pool_step(input logic op, input logic [7:0] idx, input logic [7:0] cnt,
                             output t_alloc_result r);
        r = '0;
        if (op == OP_ALLOC) begin
            if (cnt != 8'd1) begin
                r.status = ST_BAD_ALLOC_COUNT;
            end else if (head_ptr >= POOL_BLOCKS) begin
                r.status = ST_EXHAUSTED;
            end else begin
                r.granted = head_ptr[7:0];
                head_ptr  = link_mem[head_ptr];
                if (used_cnt != 8'hFF) used_cnt = used_cnt + 8'd1;
                r.status = ST_OK;
            end
        end else begin
            if (cnt != 8'd1) begin
                r.status = ST_FREE_IGNORED;
            end else if (idx >= POOL_BLOCKS) begin
                r.status = ST_OUT_OF_POOL;
            end else begin
                link_mem[idx] = head_ptr;
                head_ptr = {1'b0, idx};
                if (used_cnt != 8'd0) used_cnt = used_cnt - 8'd1;
                r.status = ST_OK;
            end
        end
        r.used  = used_cnt;
        r.freeb = (used_cnt >= POOL_BLOCKS) ? 8'd0 : 8'(POOL_BLOCKS - used_cnt);
    endtask

    function automatic t_req_row row(input logic op, input logic [7:0] idx,
                                     input logic [7:0] cnt, input bit typed,
                                     input t_alloc_result res);
        t_req_row r;
        r.op    = op;
        r.idx   = idx;
        r.cnt   = cnt;
        r.typed = typed;
        r.res   = res;
        return r;
    endfunction

    // start stays high between back-to-back transactions unless an idle gap is drawn
    task automatic send_request(input logic op, input logic [7:0] idx, input logic [7:0] cnt,
                                input bit typed, input t_alloc_result typed_res);
        t_alloc_result predicted;
        if (idle_en && $urandom_range(0, 99) < 14) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_block_index <= idx;
        i_req_count   <= cnt;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        pool_step(op, idx, cnt, predicted);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic send_random(input int alloc_pct);
        logic       op;
        logic [7:0] idx;
        logic [7:0] cnt;
        if ($urandom_range(0, 99) < 10) begin
            op  = 1'($urandom_range(0, 1));
            idx = 8'($urandom_range(0, 255));
            cnt = 8'($urandom_range(0, 255));
        end else begin
            op  = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
            cnt = ($urandom_range(0, 99) < 95) ? 8'd1 : 8'($urandom_range(0, 255));
            idx = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, POOL_BLOCKS - 1))
                                               : 8'($urandom_range(0, 255));
        end
        send_request(op, idx, cnt, 1'b0, '0);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_alloc_result got;
        t_alloc_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            got = '{o_granted_index, o_status, o_used_blocks, o_free_blocks};
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result: granted %0d status %0d used %0d free %0d",
                             got.granted, got.status, got.used, got.freeb);
            end else begin
                want = pending_results.pop_front();
                if (got.granted !== want.granted || got.status !== want.status ||
                    got.used !== want.used || got.freeb !== want.freeb) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("mismatch: exp granted %0d status %0d used %0d free %0d, %s",
                                 want.granted, want.status, want.used, want.freeb,
                                 $sformatf("got granted %0d status %0d used %0d free %0d",
                                           got.granted, got.status, got.used, got.freeb));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL fixed_block_free_list_allocator_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int  sent;
        int  phase_len;
        int  alloc_pct;
        int  k;
        bit  burst_done;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_op          <= OP_ALLOC;
        i_block_index <= '0;
        i_req_count   <= '0;
        mismatch_cnt  = 0;
        idle_cycles   = 0;
        idle_en       = 1'b1;
        sent          = 0;
        burst_done    = 1'b0;
        pool_reset();

        req_table.push_back(row(OP_ALLOC, 8'd0, 8'd1, 1'b1,
            '{8'd0, ST_OK, 8'd1, 8'(POOL_BLOCKS - 1)}));
        req_table.push_back(row(OP_ALLOC, 8'd0, 8'd0, 1'b1,
            '{8'd0, ST_BAD_ALLOC_COUNT, 8'd1, 8'(POOL_BLOCKS - 1)}));
        req_table.push_back(row(OP_ALLOC, 8'hFF, 8'hFF, 1'b1,
            '{8'd0, ST_BAD_ALLOC_COUNT, 8'd1, 8'(POOL_BLOCKS - 1)}));
        for (int i = 1; i < POOL_BLOCKS; i++)
            req_table.push_back(row(OP_ALLOC, 8'(i * 37), 8'd1, 1'b0, '0));
        req_table.push_back(row(OP_ALLOC, 8'd0, 8'd1, 1'b1,
            '{8'd0, ST_EXHAUSTED, 8'(POOL_BLOCKS), 8'd0}));
        req_table.push_back(row(OP_ALLOC, 8'd0, 8'd2, 1'b1,
            '{8'd0, ST_BAD_ALLOC_COUNT, 8'(POOL_BLOCKS), 8'd0}));
        req_table.push_back(row(OP_FREE, 8'd0, 8'd0, 1'b1,
            '{8'd0, ST_FREE_IGNORED, 8'(POOL_BLOCKS), 8'd0}));
        req_table.push_back(row(OP_FREE, 8'hFF, 8'hFF, 1'b1,
            '{8'd0, ST_FREE_IGNORED, 8'(POOL_BLOCKS), 8'd0}));
        req_table.push_back(row(OP_FREE, 8'hFF, 8'd1, 1'b1,
            '{8'd0, ST_OUT_OF_POOL, 8'(POOL_BLOCKS), 8'd0}));
        req_table.push_back(row(OP_FREE, 8'(POOL_BLOCKS), 8'd1, 1'b1,
            '{8'd0, ST_OUT_OF_POOL, 8'(POOL_BLOCKS), 8'd0}));
        // double free of the last block makes it link to itself
        req_table.push_back(row(OP_FREE, 8'(POOL_BLOCKS - 1), 8'd1, 1'b0, '0));
        req_table.push_back(row(OP_FREE, 8'(POOL_BLOCKS - 1), 8'd1, 1'b0, '0));
        req_table.push_back(row(OP_ALLOC, 8'd0, 8'd1, 1'b0, '0));
        req_table.push_back(row(OP_ALLOC, 8'd0, 8'd1, 1'b0, '0));
        req_table.push_back(row(OP_FREE, 8'd0, 8'd1, 1'b0, '0));
        req_table.push_back(row(OP_FREE, 8'd1, 8'd1, 1'b0, '0));
        req_table.push_back(row(OP_FREE, 8'd128, 8'd1, 1'b0, '0));
        req_table.push_back(row(OP_ALLOC, 8'd0, 8'd1, 1'b0, '0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (req_table[i])
            send_request(req_table[i].op, req_table[i].idx, req_table[i].cnt,
                         req_table[i].typed, req_table[i].res);
        drain();
        sent = req_table.size();

        while (sent < 600) begin
            phase_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: alloc_pct = 85;
                1: alloc_pct = 15;
                default: alloc_pct = 50;
            endcase
            idle_en = !(sent >= 250 && sent < 400);
            if (!burst_done && sent >= 300) begin
                // self-linked block keeps allocate succeeding while the used count saturates
                k = $urandom_range(0, POOL_BLOCKS - 1);
                send_request(OP_FREE, 8'(k), 8'd1, 1'b0, '0);
                send_request(OP_FREE, 8'(k), 8'd1, 1'b0, '0);
                repeat (BURST_ALLOCS) send_request(OP_ALLOC, 8'($urandom_range(0, 255)), 8'd1,
                                                   1'b0, '0);
                drain();
                sent = sent + BURST_ALLOCS + 2;
                burst_done = 1'b1;
            end
            for (int j = 0; j < phase_len; j++) begin
                send_random(alloc_pct);
                sent++;
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("PASS fixed_block_free_list_allocator_unit");
        end else begin
            $display("FAIL fixed_block_free_list_allocator_unit");
        end
        $finish;
    end

endmodule
